// ===== rtl/fio_pkg.sv =====
// ----------------------------------------------------------------------------
// fio_pkg: shared types, constants and microcode for the fade envelope
// Holds the request and phase codes, the control word layout, the
// sequencer status group and the microprogram ROM.
// ----------------------------------------------------------------------------
package fio_pkg;

    // Default sizes
    localparam int TIME_BITS_DEF  = 16;
    localparam int ALPHA_FRAC_DEF = 16;

    // Fixed port field widths
    localparam int REQ_W   = 2;
    localparam int DELTA_W = 16;
    localparam int ALPHA_W = 17;
    localparam int STATE_W = 2;
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 16;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_FADE_IN  = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_FADE_OUT = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 2'd0,
        REQ_ENABLE   = 2'd1,
        REQ_DIS_NOW  = 2'd2,
        REQ_DIS_FADE = 2'd3
    } t_req;

    typedef enum logic [STATE_W-1:0] {
        PH_IDLE = 2'd0,
        PH_IN   = 2'd1,
        PH_OUT  = 2'd2
    } t_phase;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_EMIT,
        OP_FETCH,
        OP_TRANS,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_WSET,
        OP_SNAP,
        OP_IDLE_FIN,
        OP_ENABLE,
        OP_DISABLE,
        OP_PEND
    } t_op;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_OUT_BUSY,
        C_REQ_ENA,
        C_REQ_DIS,
        C_REQ_PEND,
        C_OFF,
        C_IDLE,
        C_DONE,
        C_DIV_MORE
    } t_cond;

    localparam int STEP_W = 4;

    // Program steps
    localparam logic [STEP_W-1:0] S_EMIT     = 4'd0;
    localparam logic [STEP_W-1:0] S_FETCH    = 4'd1;
    localparam logic [STEP_W-1:0] S_CHK_ENA  = 4'd2;
    localparam logic [STEP_W-1:0] S_CHK_DIS  = 4'd3;
    localparam logic [STEP_W-1:0] S_CHK_PEND = 4'd4;
    localparam logic [STEP_W-1:0] S_CHK_OFF  = 4'd5;
    localparam logic [STEP_W-1:0] S_TRANS    = 4'd6;
    localparam logic [STEP_W-1:0] S_CHK_IDLE = 4'd7;
    localparam logic [STEP_W-1:0] S_DIV_INIT = 4'd8;
    localparam logic [STEP_W-1:0] S_DIV_STEP = 4'd9;
    localparam logic [STEP_W-1:0] S_WSET     = 4'd10;
    localparam logic [STEP_W-1:0] S_SNAP     = 4'd11;
    localparam logic [STEP_W-1:0] S_IDLE_FIN = 4'd12;
    localparam logic [STEP_W-1:0] S_ENABLE   = 4'd13;
    localparam logic [STEP_W-1:0] S_DISABLE  = 4'd14;
    localparam logic [STEP_W-1:0] S_PEND     = 4'd15;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // Status from datapath to sequencer
    typedef struct packed {
        logic no_in;
        logic out_busy;
        t_req req;
        logic off;
        logic idle;
        logic done;
        logic div_more;
    } t_stat;

    // Microprogram: jump to target when cond holds, else next step
    function automatic t_ctrl rom(input logic [STEP_W-1:0] step);
        t_ctrl w;
        unique case (step)
            S_EMIT:     w = '{OP_EMIT,     C_OUT_BUSY, S_EMIT};
            S_FETCH:    w = '{OP_FETCH,    C_NO_IN,    S_FETCH};
            S_CHK_ENA:  w = '{OP_NOP,      C_REQ_ENA,  S_ENABLE};
            S_CHK_DIS:  w = '{OP_NOP,      C_REQ_DIS,  S_DISABLE};
            S_CHK_PEND: w = '{OP_NOP,      C_REQ_PEND, S_PEND};
            S_CHK_OFF:  w = '{OP_NOP,      C_OFF,      S_EMIT};
            S_TRANS:    w = '{OP_TRANS,    C_NEVER,    S_EMIT};
            S_CHK_IDLE: w = '{OP_NOP,      C_IDLE,     S_IDLE_FIN};
            S_DIV_INIT: w = '{OP_DIV_INIT, C_DONE,     S_SNAP};
            S_DIV_STEP: w = '{OP_DIV_STEP, C_DIV_MORE, S_DIV_STEP};
            S_WSET:     w = '{OP_WSET,     C_ALWAYS,   S_EMIT};
            S_SNAP:     w = '{OP_SNAP,     C_ALWAYS,   S_EMIT};
            S_IDLE_FIN: w = '{OP_IDLE_FIN, C_ALWAYS,   S_EMIT};
            S_ENABLE:   w = '{OP_ENABLE,   C_ALWAYS,   S_EMIT};
            S_DISABLE:  w = '{OP_DISABLE,  C_ALWAYS,   S_EMIT};
            S_PEND:     w = '{OP_PEND,     C_ALWAYS,   S_EMIT};
            default:    w = '{OP_NOP,      C_ALWAYS,   S_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/fio_if.sv =====
// ----------------------------------------------------------------------------
// fio_if: channel interfaces of the fade envelope
// Request, result and configuration channels, each valid/ready.
// ----------------------------------------------------------------------------

// Request channel
interface fio_req_if;
    logic                             valid;
    logic                             ready;
    logic [fio_pkg::REQ_W-1:0]        req_type;
    logic [fio_pkg::DELTA_W-1:0]      delta_time;

    modport source (output valid, output req_type, output delta_time, input ready);
    modport sink   (input valid, input req_type, input delta_time, output ready);
endinterface

// Result channel
interface fio_res_if;
    logic                             valid;
    logic                             ready;
    logic [fio_pkg::ALPHA_W-1:0]      alpha;
    logic [fio_pkg::STATE_W-1:0]      fade_state;
    logic                             is_disabled;
    logic                             disable_pending;
    logic                             target_full;

    modport source (output valid, output alpha, output fade_state, output is_disabled,
                    output disable_pending, output target_full, input ready);
    modport sink   (input valid, input alpha, input fade_state, input is_disabled,
                    input disable_pending, input target_full, output ready);
endinterface

// Configuration write channel
interface fio_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fio_pkg::CFG_A_W-1:0]      index;
    logic [fio_pkg::CFG_D_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fio_seq.sv =====
// ----------------------------------------------------------------------------
// fio_seq: microprogram sequencer
// Step counter over the control ROM with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module fio_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fio_pkg::t_stat  i_stat,
    output fio_pkg::t_ctrl  o_ctrl
);

    logic [fio_pkg::STEP_W-1:0] r_pc;
    logic [fio_pkg::STEP_W-1:0] n_pc;
    fio_pkg::t_ctrl             w_ctrl;
    logic                       w_hit;

    // Control word of the current step
    assign w_ctrl = fio_pkg::rom(r_pc);
    assign o_ctrl = w_ctrl;

    // Jump condition select
    always_comb begin
        unique case (w_ctrl.cond)
            fio_pkg::C_NEVER:    w_hit = 1'b0;
            fio_pkg::C_ALWAYS:   w_hit = 1'b1;
            fio_pkg::C_NO_IN:    w_hit = i_stat.no_in;
            fio_pkg::C_OUT_BUSY: w_hit = i_stat.out_busy;
            fio_pkg::C_REQ_ENA:  w_hit = (i_stat.req == fio_pkg::REQ_ENABLE);
            fio_pkg::C_REQ_DIS:  w_hit = (i_stat.req == fio_pkg::REQ_DIS_NOW);
            fio_pkg::C_REQ_PEND: w_hit = (i_stat.req == fio_pkg::REQ_DIS_FADE);
            fio_pkg::C_OFF:      w_hit = i_stat.off;
            fio_pkg::C_IDLE:     w_hit = i_stat.idle;
            fio_pkg::C_DONE:     w_hit = i_stat.done;
            fio_pkg::C_DIV_MORE: w_hit = i_stat.div_more;
            default:             w_hit = 1'b1;
        endcase
        n_pc = w_hit ? w_ctrl.target : r_pc + 1'b1;
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= fio_pkg::S_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/fio_dp.sv =====
// ----------------------------------------------------------------------------
// fio_dp: envelope datapath
// Envelope state, configuration registers, restoring divider for the ramp
// and the result register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module fio_dp #(
    parameter int TIME_BITS       = fio_pkg::TIME_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = fio_pkg::ALPHA_FRAC_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fio_pkg::t_ctrl  i_ctrl,
    output fio_pkg::t_stat  o_stat,
    fio_req_if.sink         i_req,
    fio_res_if.source       o_res,
    fio_cfg_if.sink         i_cfg
);

    localparam int TB    = TIME_BITS;
    localparam int AF    = ALPHA_FRAC_BITS;
    localparam int CNT_W = $clog2(AF);
    localparam logic [AF:0] W_ONE   = {1'b1, {AF{1'b0}}};
    localparam logic [TB:0] EL_MAX  = '1;

    // Configuration
    logic [TB-1:0]           r_fade_in;
    logic [TB-1:0]           r_fade_out;

    // Envelope state
    fio_pkg::t_phase         r_phase;
    logic [TB:0]             r_elapsed;
    logic [AF:0]             r_weight;
    logic                    r_off;
    logic                    r_pend;

    // Latched request beat
    fio_pkg::t_req           r_req;
    logic [TB-1:0]           r_delta;

    // Divider
    logic [TB:0]             r_rem;
    logic [AF-1:0]           r_quo;
    logic [CNT_W-1:0]        r_cnt;

    // Result register
    logic                    r_out_valid;
    logic [AF:0]             r_out_alpha;
    fio_pkg::t_phase         r_out_state;
    logic                    r_out_off;
    logic                    r_out_pend;

    logic                    w_accept;
    logic                    w_out_busy;
    logic                    w_load;
    fio_pkg::t_phase         n_phase;
    logic                    w_clr;
    logic [TB:0]             w_base;
    logic [TB+1:0]           w_sum;
    logic [TB:0]             n_elapsed;
    logic [TB:0]             w_span;
    logic [TB:0]             w_shift;
    logic                    w_ge;
    logic                    w_in_done;
    logic                    w_out_done;

    // Handshakes, closed while reset is held
    assign i_cfg.ready = i_rst_n;
    assign i_req.ready = (i_ctrl.op == fio_pkg::OP_FETCH) && i_rst_n;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_busy  = r_out_valid && !o_res.ready;
    assign w_load      = (i_ctrl.op == fio_pkg::OP_EMIT) && !w_out_busy;

    // Fade-complete tests
    assign w_in_done  = (r_fade_in == '0) || ({1'b0, r_fade_in} <= r_elapsed);
    assign w_out_done = (r_fade_out == '0) || ({1'b0, r_fade_out} <= r_elapsed);

    // Status to sequencer
    assign o_stat.no_in    = !i_req.valid;
    assign o_stat.out_busy = w_out_busy;
    assign o_stat.req      = r_req;
    assign o_stat.off      = r_off;
    assign o_stat.idle     = (r_phase == fio_pkg::PH_IDLE);
    assign o_stat.done     = (r_phase == fio_pkg::PH_IN) ? w_in_done : w_out_done;
    assign o_stat.div_more = (r_cnt != '0);

    // Phase transitions on a tick, then elapsed advance with saturation
    always_comb begin
        n_phase = r_phase;
        w_clr   = 1'b0;
        unique case (r_phase)
            fio_pkg::PH_IDLE: begin
                if (!r_pend && (r_weight < W_ONE)) begin
                    n_phase = fio_pkg::PH_IN;
                    w_clr   = 1'b1;
                end else if (r_pend && (r_weight != '0)) begin
                    n_phase = fio_pkg::PH_OUT;
                    w_clr   = 1'b1;
                end
            end
            fio_pkg::PH_IN: begin
                if (r_pend) begin
                    n_phase = fio_pkg::PH_OUT;
                    w_clr   = 1'b1;
                end
            end
            fio_pkg::PH_OUT: begin
                if (!r_pend) begin
                    n_phase = fio_pkg::PH_IN;
                    w_clr   = 1'b1;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        w_base = w_clr ? '0 : r_elapsed;
        w_sum  = {1'b0, w_base} + (TB+2)'(r_delta);
        if (n_phase == fio_pkg::PH_IDLE) begin
            n_elapsed = w_base;
        end else begin
            n_elapsed = w_sum[TB+1] ? EL_MAX : w_sum[TB:0];
        end
    end

    // One restoring divide step: remainder below the span fits TB bits
    assign w_span  = (r_phase == fio_pkg::PH_IN) ? {1'b0, r_fade_in} : {1'b0, r_fade_out};
    assign w_shift = {r_rem[TB-1:0], 1'b0};
    assign w_ge    = (w_shift >= w_span);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_in  <= '0;
            r_fade_out <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == fio_pkg::CFG_FADE_IN) begin
                r_fade_in <= TB'(i_cfg.data);
            end
            if (i_cfg.index == fio_pkg::CFG_FADE_OUT) begin
                r_fade_out <= TB'(i_cfg.data);
            end
        end
    end

    // Request beat capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= fio_pkg::t_req'(i_req.req_type);
            r_delta <= TB'(i_req.delta_time);
        end
    end

    // Divider registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == fio_pkg::OP_DIV_INIT) begin
            r_rem <= {1'b0, r_elapsed[TB-1:0]};
            r_quo <= '0;
            r_cnt <= CNT_W'(AF - 1);
        end else if (i_ctrl.op == fio_pkg::OP_DIV_STEP) begin
            r_rem <= w_ge ? w_shift - w_span : w_shift;
            r_quo <= {r_quo[AF-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Envelope state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= fio_pkg::PH_IDLE;
            r_elapsed <= '0;
            r_weight  <= '0;
            r_off     <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            unique case (i_ctrl.op)
                fio_pkg::OP_TRANS: begin
                    r_phase   <= n_phase;
                    r_elapsed <= n_elapsed;
                end
                fio_pkg::OP_WSET: begin
                    if (r_phase == fio_pkg::PH_IN) begin
                        r_weight <= {1'b0, r_quo};
                    end else begin
                        r_weight <= W_ONE - {1'b0, r_quo};
                    end
                end
                fio_pkg::OP_SNAP: begin
                    r_phase <= fio_pkg::PH_IDLE;
                    if (r_phase == fio_pkg::PH_IN) begin
                        r_weight <= W_ONE;
                    end else begin
                        r_weight <= '0;
                        // blended disable completes here
                        if (r_pend) begin
                            r_off  <= 1'b1;
                            r_pend <= 1'b0;
                        end
                    end
                end
                fio_pkg::OP_IDLE_FIN: begin
                    if (!r_pend) begin
                        r_weight <= W_ONE;
                    end
                end
                fio_pkg::OP_ENABLE: begin
                    r_off     <= 1'b0;
                    r_pend    <= 1'b0;
                    r_weight  <= '0;
                    r_elapsed <= '0;
                    r_phase   <= fio_pkg::PH_IDLE;
                end
                fio_pkg::OP_DISABLE: begin
                    r_off    <= 1'b1;
                    r_weight <= '0;
                    r_pend   <= 1'b0;
                end
                fio_pkg::OP_PEND: begin
                    r_pend <= 1'b1;
                end
                default: begin
                    r_phase <= r_phase;
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_alpha <= r_weight;
            r_out_state <= r_phase;
            r_out_off   <= r_off;
            r_out_pend  <= r_pend;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.alpha           = fio_pkg::ALPHA_W'(r_out_alpha);
    assign o_res.fade_state      = r_out_state;
    assign o_res.is_disabled     = r_out_off;
    assign o_res.disable_pending = r_out_pend;
    assign o_res.target_full     = !(r_out_off || r_out_pend);

endmodule

// ===== rtl/fade_in_out_envelope.sv =====
// ----------------------------------------------------------------------------
// fade_in_out_envelope: linear fade-in / fade-out blend-weight envelope
// Microcoded sequencer over a small datapath; one result beat per request.
//
//   channel  dir  beat contents
//   i_req    in   req_type, delta_time
//   o_res    out  alpha, fade_state, is_disabled, disable_pending, target_full
//   i_cfg    in   index (0 fade-in time, 1 fade-out time), data
//
// A tick that is still ramping runs the restoring divider before the result
// load; the divider retires one quotient bit per cycle. Other requests, and
// ticks whose fade is already complete, skip the divide steps.
// One request is in flight at a time; the next beat is taken once the
// result is loaded. A stalled result register holds the sequencer at the
// emit step. Synchronous active-low reset; i_cfg is always ready out of reset.
// ----------------------------------------------------------------------------
module fade_in_out_envelope #(
    parameter int TIME_BITS       = fio_pkg::TIME_BITS_DEF,
    parameter int ALPHA_FRAC_BITS = fio_pkg::ALPHA_FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fio_req_if.sink     i_req,
    fio_res_if.source   o_res,
    fio_cfg_if.sink     i_cfg
);

    fio_pkg::t_ctrl w_ctrl;
    fio_pkg::t_stat w_stat;

    // Program sequencer
    fio_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // Datapath
    fio_dp #(
        .TIME_BITS       (TIME_BITS),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat),
        .i_req   (i_req),
        .o_res   (o_res),
        .i_cfg   (i_cfg)
    );

endmodule
